// ===== rtl/ibmw_pkg.sv =====
// Shared types, codes and constants of the indirect block map walker.
`default_nettype none

package ibmw_pkg;

    // Default buffer depth, in pointers per block (power of two)
    localparam int unsigned MAX_PTRS_DEF = 1024;

    // Mount slots that may tag the cache
    localparam int unsigned MOUNT_SLOTS = 4;

    // Inode pointer layout
    localparam int unsigned NUM_INODE_PTRS = 15;
    localparam int unsigned DIRECT_PTRS    = 12;
    localparam int unsigned SINGLE_SLOT    = 12;
    localparam int unsigned DOUBLE_SLOT    = 13;
    localparam int unsigned TRIPLE_SLOT    = 14;

    // log2 of pointers per block at the smallest block size
    localparam int unsigned BASE_PTR_LOG = 8;

    // Command codes
    localparam logic [1:0] CMD_LOAD_PTR   = 2'd0;
    localparam logic [1:0] CMD_MAP        = 2'd1;
    localparam logic [1:0] CMD_FETCH_WORD = 2'd2;

    // Result kinds
    localparam logic KIND_FETCH  = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE_LOG = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT    = 2'd1;

    // Request word
    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  mount_slot;
        logic [3:0]  slot_index;
        logic [31:0] word_value;
        logic [31:0] logical_block;
    } ibmw_in_t;

    // Response word
    typedef struct packed {
        logic        kind;
        logic [31:0] block_number;
        logic        out_of_range;
    } ibmw_out_t;

    // Configuration view handed to the walker
    typedef struct packed {
        logic [1:0]  block_size_log;
        logic [31:0] block_count;
        logic        wr;
    } ibmw_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ibmw_buf_mem.sv =====
// Indirect block buffer: one write port, one read port, registered read data.
`default_nettype none

module ibmw_buf_mem #(
    parameter int unsigned DEPTH  = ibmw_pkg::MAX_PTRS_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [31:0]       wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [31:0]       rdata
);

    logic [31:0] mem [DEPTH];

    // Write fetched words
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, enabled by re
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ibmw_walker.sv =====
// Walker control: inode pointers, cache tag, fill sequencing and level walk.
`default_nettype none

module ibmw_walker #(
    parameter int unsigned MAX_PTRS = ibmw_pkg::MAX_PTRS_DEF,
    parameter int unsigned ADDR_W   = $clog2(MAX_PTRS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ibmw_pkg::ibmw_cfg_t cfg,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire ibmw_pkg::ibmw_in_t  req_data,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output ibmw_pkg::ibmw_out_t      res_data,
    output logic                     mem_we,
    output logic [ADDR_W-1:0]        mem_waddr,
    output logic [31:0]              mem_wdata,
    output logic                     mem_re,
    output logic [ADDR_W-1:0]        mem_raddr,
    input  wire logic [31:0]         mem_rdata
);

    import ibmw_pkg::*;

    localparam int unsigned SH_W = 5;
    localparam logic [1:0] LEVEL_SINGLE = 2'd1;
    localparam logic [1:0] LEVEL_DOUBLE = 2'd2;
    localparam logic [1:0] LEVEL_TRIPLE = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_READ   = 5'b01000,
        ST_EMIT   = 5'b10000
    } walk_state_t;

    walk_state_t       state_reg, state_next;
    logic [31:0]       ptr_reg [NUM_INODE_PTRS];
    logic [31:0]       ptr_next [NUM_INODE_PTRS];
    logic              cache_valid_reg, cache_valid_next;
    logic              fetch_pending_reg, fetch_pending_next;
    logic [ADDR_W-1:0] fill_count_reg, fill_count_next;
    logic [31:0]       cached_block_reg, cached_block_next;
    logic [1:0]        cached_mount_reg, cached_mount_next;
    logic [1:0]        walk_level_reg, walk_level_next;
    logic [31:0]       walk_rem_reg, walk_rem_next;
    logic [1:0]        walk_mount_reg, walk_mount_next;
    logic [31:0]       cur_ptr_reg, cur_ptr_next;
    logic [1:0]        cur_level_reg, cur_level_next;
    logic [31:0]       cur_rem_reg, cur_rem_next;
    logic [1:0]        cur_mount_reg, cur_mount_next;
    ibmw_out_t         res_reg, res_next;

    logic              accept;
    logic [1:0]        lg_capped;
    logic [SH_W-1:0]   k_raw;
    logic [SH_W-1:0]   k_eff;
    logic [31:0]       ppb_mask;
    logic [31:0]       lim1, lim2, lim3;
    logic [31:0]       rem1, rem2, rem3;
    logic [SH_W-1:0]   sh;
    logic [31:0]       idx_wide;
    logic [31:0]       rem_mask;
    logic              cache_hit;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res_data  = res_reg;

    // Pointers per block: code 3 acts as 2, capped at the buffer depth
    always_comb
    begin
        lg_capped = (cfg.block_size_log > 2'd2) ? 2'd2 : cfg.block_size_log;
        k_raw     = SH_W'(BASE_PTR_LOG) + SH_W'(lg_capped);
        k_eff     = (k_raw > SH_W'(ADDR_W)) ? SH_W'(ADDR_W) : k_raw;
        ppb_mask  = (32'd1 << k_eff) - 32'd1;
    end

    // Level boundaries; the powers are disjoint bits, so OR adds them
    always_comb
    begin
        lim1 = 32'(DIRECT_PTRS) | (32'd1 << k_eff);
        lim2 = lim1 | (32'd1 << (k_eff + k_eff));
        lim3 = lim2 | (32'd1 << (k_eff + k_eff + k_eff));
        rem1 = cur_rem_reg - 32'(DIRECT_PTRS);
        rem2 = cur_rem_reg - lim1;
        rem3 = cur_rem_reg - lim2;
    end

    // Buffer index and remainder mask of the current level
    always_comb
    begin
        if (cur_level_reg == LEVEL_TRIPLE)
        begin
            sh = k_eff + k_eff;
        end
        else if (cur_level_reg == LEVEL_DOUBLE)
        begin
            sh = k_eff;
        end
        else
        begin
            sh = '0;
        end
        idx_wide = (cur_rem_reg >> sh) & ppb_mask;
        rem_mask = (32'd1 << sh) - 32'd1;
    end

    assign cache_hit = cache_valid_reg && (cached_mount_reg == cur_mount_reg) &&
                       (cached_block_reg == cur_ptr_reg);

    // Buffer ports: fill on fetched words, read only once a fill is complete
    assign mem_we    = accept && (req_data.cmd == CMD_FETCH_WORD) && fetch_pending_reg;
    assign mem_waddr = fill_count_reg;
    assign mem_wdata = req_data.word_value;
    assign mem_re    = (state_reg == ST_WALK) && (cur_ptr_reg != 32'd0) && cache_hit;
    assign mem_raddr = idx_wide[ADDR_W-1:0];

    // Next state
    always_comb
    begin
        state_next         = state_reg;
        ptr_next           = ptr_reg;
        cache_valid_next   = cache_valid_reg;
        fetch_pending_next = fetch_pending_reg;
        fill_count_next    = fill_count_reg;
        cached_block_next  = cached_block_reg;
        cached_mount_next  = cached_mount_reg;
        walk_level_next    = walk_level_reg;
        walk_rem_next      = walk_rem_reg;
        walk_mount_next    = walk_mount_reg;
        cur_ptr_next       = cur_ptr_reg;
        cur_level_next     = cur_level_reg;
        cur_rem_next       = cur_rem_reg;
        cur_mount_next     = cur_mount_reg;
        res_next           = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.cmd)
                        CMD_LOAD_PTR:
                        begin
                            if (req_data.slot_index < 4'(NUM_INODE_PTRS))
                            begin
                                ptr_next[req_data.slot_index] = req_data.word_value;
                            end
                        end
                        CMD_MAP:
                        begin
                            // Drop any pending fetch and decode the request
                            fetch_pending_next = 1'b0;
                            fill_count_next    = '0;
                            cur_rem_next       = req_data.logical_block;
                            cur_mount_next     = req_data.mount_slot;
                            state_next         = ST_DECODE;
                        end
                        CMD_FETCH_WORD:
                        begin
                            if (fetch_pending_reg)
                            begin
                                if (fill_count_reg == ppb_mask[ADDR_W-1:0])
                                begin
                                    // Last word: mark cached and resume the walk
                                    fetch_pending_next = 1'b0;
                                    fill_count_next    = '0;
                                    cache_valid_next   = 1'b1;
                                    cur_ptr_next       = cached_block_reg;
                                    cur_level_next     = walk_level_reg;
                                    cur_rem_next       = walk_rem_reg;
                                    cur_mount_next     = walk_mount_reg;
                                    state_next         = ST_WALK;
                                end
                                else
                                begin
                                    fill_count_next = fill_count_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_DECODE:
            begin
                res_next.kind         = KIND_RESULT;
                res_next.block_number = 32'd0;
                res_next.out_of_range = 1'b0;
                if (5'(cur_mount_reg) >= 5'(MOUNT_SLOTS))
                begin
                    res_next.out_of_range = 1'b1;
                    state_next            = ST_EMIT;
                end
                else if (cur_rem_reg < 32'(DIRECT_PTRS))
                begin
                    res_next.block_number = ptr_reg[cur_rem_reg[3:0]];
                    state_next            = ST_EMIT;
                end
                else if (cur_rem_reg < lim1)
                begin
                    cur_ptr_next   = ptr_reg[SINGLE_SLOT];
                    cur_level_next = LEVEL_SINGLE;
                    cur_rem_next   = rem1;
                    state_next     = ST_WALK;
                end
                else if (cur_rem_reg < lim2)
                begin
                    cur_ptr_next   = ptr_reg[DOUBLE_SLOT];
                    cur_level_next = LEVEL_DOUBLE;
                    cur_rem_next   = rem2;
                    state_next     = ST_WALK;
                end
                else if (cur_rem_reg < lim3)
                begin
                    cur_ptr_next   = ptr_reg[TRIPLE_SLOT];
                    cur_level_next = LEVEL_TRIPLE;
                    cur_rem_next   = rem3;
                    state_next     = ST_WALK;
                end
                else
                begin
                    // Beyond triple indirect reach
                    res_next.out_of_range = 1'b1;
                    state_next            = ST_EMIT;
                end
            end

            ST_WALK:
            begin
                res_next.kind         = KIND_RESULT;
                res_next.block_number = 32'd0;
                res_next.out_of_range = 1'b0;
                if (cur_ptr_reg == 32'd0)
                begin
                    // Hole
                    state_next = ST_EMIT;
                end
                else if (cache_hit)
                begin
                    state_next = ST_READ;
                end
                else if (cur_ptr_reg >= cfg.block_count)
                begin
                    cache_valid_next      = 1'b0;
                    res_next.out_of_range = 1'b1;
                    state_next            = ST_EMIT;
                end
                else
                begin
                    // Miss: retag the buffer and request the block
                    cache_valid_next      = 1'b0;
                    cached_block_next     = cur_ptr_reg;
                    cached_mount_next     = cur_mount_reg;
                    fetch_pending_next    = 1'b1;
                    fill_count_next       = '0;
                    walk_level_next       = cur_level_reg;
                    walk_rem_next         = cur_rem_reg;
                    walk_mount_next       = cur_mount_reg;
                    res_next.kind         = KIND_FETCH;
                    res_next.block_number = cur_ptr_reg;
                    state_next            = ST_EMIT;
                end
            end

            ST_READ:
            begin
                if (cur_level_reg <= LEVEL_SINGLE)
                begin
                    res_next.kind         = KIND_RESULT;
                    res_next.block_number = mem_rdata;
                    res_next.out_of_range = 1'b0;
                    state_next            = ST_EMIT;
                end
                else
                begin
                    // Descend one level
                    cur_ptr_next   = mem_rdata;
                    cur_rem_next   = cur_rem_reg & rem_mask;
                    cur_level_next = cur_level_reg - 2'd1;
                    state_next     = ST_WALK;
                end
            end

            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes invalidate the cache and abandon a fetch
        if (cfg.wr)
        begin
            cache_valid_next   = 1'b0;
            fetch_pending_next = 1'b0;
            fill_count_next    = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cache_valid_reg   <= 1'b0;
            fetch_pending_reg <= 1'b0;
            fill_count_reg    <= '0;
            for (int i = 0; i < NUM_INODE_PTRS; i++)
            begin
                ptr_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            cache_valid_reg   <= cache_valid_next;
            fetch_pending_reg <= fetch_pending_next;
            fill_count_reg    <= fill_count_next;
            ptr_reg           <= ptr_next;
        end
    end

    // Tags, saved walk and working registers
    always_ff @(posedge clk)
    begin
        cached_block_reg <= cached_block_next;
        cached_mount_reg <= cached_mount_next;
        walk_level_reg   <= walk_level_next;
        walk_rem_reg     <= walk_rem_next;
        walk_mount_reg   <= walk_mount_next;
        cur_ptr_reg      <= cur_ptr_next;
        cur_level_reg    <= cur_level_next;
        cur_rem_reg      <= cur_rem_next;
        cur_mount_reg    <= cur_mount_next;
        res_reg          <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/indirect_block_map_walker_core.sv =====
// Top level of the indirect block map walker: config registers, output register.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_ready  | ibmw_in_t  (cmd, operands)
//   rsp     | out       | rsp_valid/rsp_ready  | ibmw_out_t (fetch or result)
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Pointer loads and fetched words are taken while idle, so a block streams in
// at one word per cycle unless a configuration write is pending. A map goes
// through decode, then walk and read for each of R buffer reads (0..3), then
// emit. Buffer reads are registered. The last fetched word resumes the walk.
// Reset clears control state and inode pointers; the buffer is never cleared.
// A full output register holds the walker in emit, stalling loads and fills too.

`default_nettype none

module indirect_block_map_walker_core #(
    parameter int unsigned MAX_PTRS_PER_BLOCK = ibmw_pkg::MAX_PTRS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_ready,
    input  wire ibmw_pkg::ibmw_in_t                    req_data,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_ready,
    output ibmw_pkg::ibmw_out_t                        rsp_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ibmw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [31:0]                           cfg_data
);

    import ibmw_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MAX_PTRS_PER_BLOCK);

    logic              walk_idle;
    logic              res_valid;
    logic              res_ready;
    ibmw_out_t         res_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [31:0]       mem_rdata;
    logic [1:0]        block_size_log_reg;
    logic [31:0]       block_count_reg;
    logic              cfg_accept;
    ibmw_cfg_t         cfg;
    logic              rsp_valid_reg;
    ibmw_out_t         rsp_data_reg;

    // Configuration takes priority over requests while the walker is idle
    assign cfg_ready  = walk_idle;
    assign req_ready  = walk_idle && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg.block_size_log = block_size_log_reg;
        cfg.block_count    = block_count_reg;
        cfg.wr             = cfg_accept && ((cfg_index == REG_BLOCK_SIZE_LOG) ||
                                            (cfg_index == REG_BLOCK_COUNT));
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_log_reg <= 2'd0;
            block_count_reg    <= 32'd0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE_LOG: block_size_log_reg <= cfg_data[1:0];
                REG_BLOCK_COUNT:    block_count_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ibmw_walker #(
        .MAX_PTRS (MAX_PTRS_PER_BLOCK),
        .ADDR_W   (ADDR_W)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid && !cfg_valid),
        .req_ready (walk_idle),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ibmw_buf_mem #(
        .DEPTH  (MAX_PTRS_PER_BLOCK),
        .ADDR_W (ADDR_W)
    ) u_buf_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: load when empty or being drained
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

// ===== rtl/ibmw_checker.sv =====
// Port-level checks of the walker core, bound to the top level.
`default_nettype none

module ibmw_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    input  wire logic                             req_ready,
    input  wire ibmw_pkg::ibmw_in_t               req_data,
    input  wire logic                             rsp_valid,
    input  wire logic                             rsp_ready,
    input  wire ibmw_pkg::ibmw_out_t              rsp_data,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [ibmw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    import ibmw_pkg::*;

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response word changed while stalled");

    // A map request keeps the walker busy the next cycle
    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.cmd == CMD_MAP) |=> !req_ready)
        else $error("request taken during a walk");

    // A pointer load leaves the walker idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.cmd == CMD_LOAD_PTR) |=>
            req_ready || cfg_valid)
        else $error("pointer load made the walker busy");

    // Configuration and request words never land together
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && req_valid && req_ready))
        else $error("config write taken with a request");

    // Fetch requests never flag a range error
    a_fetch_oor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.kind == KIND_FETCH) |-> !rsp_data.out_of_range)
        else $error("fetch request flagged out of range");

endmodule

bind indirect_block_map_walker_core ibmw_checker u_ibmw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire
